// ===== rtl/wns_pkg.sv =====
// Shared types and constants for the windowed note statistics block.
`default_nettype none
package wns_pkg;

  // Counter sizing
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int AVG_FRAC   = 8;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int NOTE_W     = 7;
  localparam int SUM_W      = COUNT_BITS + NOTE_W;

  // Result widths
  localparam int DENSITY_W  = 24;
  localparam int AVERAGE_W  = 15;
  localparam logic [DENSITY_W-1:0] DENSITY_MAX = {DENSITY_W{1'b1}};
  localparam logic [AVERAGE_W-1:0] AVERAGE_MAX = {AVERAGE_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  // Milliseconds per second scaling for the density
  localparam int MS_W = 10;
  localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
  localparam int PROD_W = COUNT_BITS + MS_W;

  // Shared divider sizing
  localparam int DENS_DIVIDEND_W = PROD_W + FRAC_BITS;
  localparam int AVG_DIVIDEND_W  = SUM_W + AVG_FRAC;
  localparam int DIVIDEND_A      = (DENS_DIVIDEND_W > AVG_DIVIDEND_W) ?
                                   DENS_DIVIDEND_W : AVG_DIVIDEND_W;
  localparam int DIVIDEND_W      = (DIVIDEND_A > DENSITY_W) ? DIVIDEND_A : DENSITY_W + 1;
  localparam int DIVISOR_W       = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
  localparam int STEP_W          = $clog2(DIVIDEND_W + 1);

  // Configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MS      = 2'd0,
    CFG_KICK_PITCH     = 2'd1,
    CFG_KICK_VELOCITY  = 2'd2,
    CFG_KICK_COUNT_MIN = 2'd3
  } cfg_idx_t;

  localparam logic [WIN_W-1:0]      WINDOW_MS_RESET      = WIN_W'(2000);
  localparam logic [NOTE_W-1:0]     KICK_PITCH_RESET     = NOTE_W'(48);
  localparam logic [NOTE_W-1:0]     KICK_VELOCITY_RESET  = NOTE_W'(80);
  localparam logic [CFG_DATA_W-1:0] KICK_COUNT_MIN_RESET = CFG_DATA_W'(5);

  // Item opcodes
  localparam logic OP_TIME = 1'b0;
  localparam logic OP_NOTE = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DENS,
    ST_AVG,
    ST_PUBLISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;       // request taken this cycle
    logic load_dens;    // start density division, restart window
    logic div_step;     // advance divider by one bit
    logic store_dens;   // publish density, start average division
    logic store_avg;    // publish average, clear counts
    logic out_direct;   // load output with an open-window result
    logic out_pending;  // load output with the held result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic closes;       // current request closes the window
    logic div_done;     // divider finished all steps
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/wns_ctrl.sv =====
// Controller state machine for the windowed note statistics block.
`default_nettype none
module wns_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire wns_pkg::status_t  stat,
  output wns_pkg::cmd_t          cmd
);

  wns_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;
  logic            accept;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && (state == wns_pkg::ST_IDLE);
  assign in_stall = (state != wns_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wns_pkg::ST_IDLE: begin
        if (accept) begin
          if (stat.closes) state_next = wns_pkg::ST_DENS;
          else if (!out_free) state_next = wns_pkg::ST_PUBLISH;
        end
      end
      wns_pkg::ST_DENS: begin
        if (stat.div_done) state_next = wns_pkg::ST_AVG;
      end
      wns_pkg::ST_AVG: begin
        if (stat.div_done) state_next = wns_pkg::ST_PUBLISH;
      end
      wns_pkg::ST_PUBLISH: begin
        if (out_free) state_next = wns_pkg::ST_IDLE;
      end
      default: state_next = wns_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      wns_pkg::ST_IDLE: begin
        cmd.accept     = accept;
        cmd.load_dens  = accept && stat.closes;
        cmd.out_direct = accept && !stat.closes && out_free;
      end
      wns_pkg::ST_DENS: begin
        cmd.div_step   = !stat.div_done;
        cmd.store_dens = stat.div_done;
      end
      wns_pkg::ST_AVG: begin
        cmd.div_step  = !stat.div_done;
        cmd.store_avg = stat.div_done;
      end
      wns_pkg::ST_PUBLISH: begin
        cmd.out_pending = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_direct || cmd.out_pending) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wns_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wns_dp.sv =====
// Datapath: counters, shared serial divider, published values and output register.
`default_nettype none
module wns_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire wns_pkg::cmd_t                      cmd,
  output wns_pkg::status_t                        stat,
  input  wire logic                               cfg_we,
  input  wire logic [wns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wns_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               op,
  input  wire logic [wns_pkg::TIME_W-1:0]         current_time,
  input  wire logic [wns_pkg::NOTE_W-1:0]         pitch,
  input  wire logic [wns_pkg::NOTE_W-1:0]         velocity,
  output logic      [wns_pkg::DENSITY_W-1:0]      density,
  output logic      [wns_pkg::AVERAGE_W-1:0]      velocity_average,
  output logic                                    kick_heavy,
  output logic                                    window_closed
);

  // Configuration registers
  logic [wns_pkg::WIN_W-1:0]      window_ms;
  logic [wns_pkg::NOTE_W-1:0]     kick_pitch_limit;
  logic [wns_pkg::NOTE_W-1:0]     kick_velocity_min;
  logic [wns_pkg::CFG_DATA_W-1:0] kick_count_min;

  // Window state
  logic [wns_pkg::TIME_W-1:0]     window_start;
  logic [wns_pkg::COUNT_BITS-1:0] note_count;
  logic [wns_pkg::SUM_W-1:0]      velocity_sum;
  logic [wns_pkg::COUNT_BITS-1:0] kick_count;
  logic [wns_pkg::DENSITY_W-1:0]  density_value;
  logic [wns_pkg::AVERAGE_W-1:0]  average_value;
  logic                           kick_flag;
  logic                           held_closed;

  // Divider registers
  logic [wns_pkg::DIVIDEND_W-1:0] dq;
  logic [wns_pkg::DIVISOR_W:0]    rem;
  logic [wns_pkg::DIVISOR_W-1:0]  divisor;
  logic [wns_pkg::STEP_W-1:0]     steps;

  logic [wns_pkg::TIME_W-1:0]     elapsed;
  logic                           is_note;
  logic                           is_kick;
  logic                           count_full;
  logic [wns_pkg::PROD_W-1:0]     prod;
  logic [wns_pkg::DIVIDEND_W-1:0] dens_dividend;
  logic [wns_pkg::DIVIDEND_W-1:0] avg_dividend;
  logic [wns_pkg::DIVISOR_W:0]    shifted;
  logic                           fits;
  logic [wns_pkg::DENSITY_W-1:0]  dens_result;
  logic [wns_pkg::AVERAGE_W-1:0]  avg_result;

  // Decode the request
  assign is_note    = (op == wns_pkg::OP_NOTE);
  assign elapsed    = current_time - window_start;
  assign stat.closes = !is_note && (elapsed >= wns_pkg::TIME_W'(window_ms));
  assign count_full = (note_count == wns_pkg::COUNT_MAX);
  assign is_kick    = (pitch < kick_pitch_limit) && (velocity > kick_velocity_min);

  // Divider operands
  assign prod = wns_pkg::PROD_W'(note_count) * wns_pkg::PROD_W'(wns_pkg::MS_PER_S);
  assign dens_dividend = wns_pkg::DIVIDEND_W'({prod, {wns_pkg::FRAC_BITS{1'b0}}});
  assign avg_dividend  = wns_pkg::DIVIDEND_W'({velocity_sum, {wns_pkg::AVG_FRAC{1'b0}}});

  // One restoring step
  assign shifted = {rem[wns_pkg::DIVISOR_W-1:0], dq[wns_pkg::DIVIDEND_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});
  assign stat.div_done = (steps == '0);

  // Saturate and special-case the quotients
  always_comb begin
    if (window_ms == '0) begin
      dens_result = (note_count != '0) ? wns_pkg::DENSITY_MAX : '0;
    end else if (dq > wns_pkg::DIVIDEND_W'(wns_pkg::DENSITY_MAX)) begin
      dens_result = wns_pkg::DENSITY_MAX;
    end else begin
      dens_result = dq[wns_pkg::DENSITY_W-1:0];
    end
  end

  always_comb begin
    if (note_count == '0) begin
      avg_result = average_value >> 1;
    end else if (dq > wns_pkg::DIVIDEND_W'(wns_pkg::AVERAGE_MAX)) begin
      avg_result = wns_pkg::AVERAGE_MAX;
    end else begin
      avg_result = dq[wns_pkg::AVERAGE_W-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms         <= wns_pkg::WINDOW_MS_RESET;
      kick_pitch_limit  <= wns_pkg::KICK_PITCH_RESET;
      kick_velocity_min <= wns_pkg::KICK_VELOCITY_RESET;
      kick_count_min    <= wns_pkg::KICK_COUNT_MIN_RESET;
    end else if (cfg_we) begin
      unique case (wns_pkg::cfg_idx_t'(cfg_index))
        wns_pkg::CFG_WINDOW_MS:      window_ms         <= cfg_data[wns_pkg::WIN_W-1:0];
        wns_pkg::CFG_KICK_PITCH:     kick_pitch_limit  <= cfg_data[wns_pkg::NOTE_W-1:0];
        wns_pkg::CFG_KICK_VELOCITY:  kick_velocity_min <= cfg_data[wns_pkg::NOTE_W-1:0];
        wns_pkg::CFG_KICK_COUNT_MIN: kick_count_min    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window counters and published values
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      note_count    <= '0;
      velocity_sum  <= '0;
      kick_count    <= '0;
      density_value <= '0;
      average_value <= '0;
      kick_flag     <= 1'b0;
    end else begin
      if (cmd.accept && is_note && !count_full) begin
        note_count   <= note_count + 1'b1;
        velocity_sum <= velocity_sum + wns_pkg::SUM_W'(velocity);
        if (is_kick) kick_count <= kick_count + 1'b1;
      end
      if (cmd.load_dens) begin
        window_start <= current_time;
        kick_flag    <= (wns_pkg::CFG_DATA_W'(kick_count) >= kick_count_min);
      end
      if (cmd.store_dens) density_value <= dens_result;
      if (cmd.store_avg) begin
        average_value <= avg_result;
        note_count    <= '0;
        velocity_sum  <= '0;
        kick_count    <= '0;
      end
    end
  end

  // Remember whether the request in flight closed the window
  always_ff @(posedge clk) begin
    if (rst) begin
      held_closed <= 1'b0;
    end else if (cmd.accept) begin
      held_closed <= stat.closes;
    end
  end

  // Shared serial divider: load, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.load_dens) begin
      steps <= wns_pkg::STEP_W'(wns_pkg::DIVIDEND_W);
    end else if (cmd.store_dens) begin
      steps <= wns_pkg::STEP_W'(wns_pkg::DIVIDEND_W);
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dens) begin
      dq      <= dens_dividend;
      rem     <= '0;
      divisor <= wns_pkg::DIVISOR_W'(window_ms);
    end else if (cmd.store_dens) begin
      dq      <= avg_dividend;
      rem     <= '0;
      divisor <= wns_pkg::DIVISOR_W'(note_count);
    end else if (cmd.div_step) begin
      dq  <= {dq[wns_pkg::DIVIDEND_W-2:0], fits};
      rem <= fits ? (shifted - {1'b0, divisor}) : shifted;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_direct || cmd.out_pending) begin
      density          <= density_value;
      velocity_average <= average_value;
      kick_heavy       <= kick_flag;
      window_closed    <= cmd.out_pending && held_closed;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/windowed_note_statistics.sv =====
// Top level of the windowed note statistics block.
//
// Input channel (in_valid / in_stall): one request per item, op selects a time
// item (current_time) or a note event (pitch, velocity). A request is taken
// when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): one result per request carrying the
// published density, average velocity, kick flag and a window_closed bit.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// write only while no request is in flight.
// A note event or a time item that does not close the window shows its
// result in the cycle after it is taken; such requests are taken every cycle
// while the output is not stalled.
// A time item that closes the window runs two divisions back to back on one
// shared restoring divider, density then average, each a load followed by one
// step per quotient bit; only then is its result published.
// When the output is stalled the result waits in the output register and the
// next request is still taken; its result is held inside until the output
// frees up, and no further request is taken meanwhile.
// Reset clears counts and published values and restores register defaults.
`default_nettype none
module windowed_note_statistics (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              op,
  input  wire logic [wns_pkg::TIME_W-1:0]        current_time,
  input  wire logic [wns_pkg::NOTE_W-1:0]        pitch,
  input  wire logic [wns_pkg::NOTE_W-1:0]        velocity,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [wns_pkg::DENSITY_W-1:0]     density,
  output logic      [wns_pkg::AVERAGE_W-1:0]     velocity_average,
  output logic                                   kick_heavy,
  output logic                                   window_closed,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wns_pkg::CFG_DATA_W-1:0]    cfg_data
);

  wns_pkg::cmd_t    cmd;
  wns_pkg::status_t stat;

  // Register writes never wait: cfg_ready is tied high
  assign cfg_ready = 1'b1;

  wns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wns_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .op               (op),
    .current_time     (current_time),
    .pitch            (pitch),
    .velocity         (velocity),
    .density          (density),
    .velocity_average (velocity_average),
    .kick_heavy       (kick_heavy),
    .window_closed    (window_closed)
  );

endmodule
`default_nettype wire

// ===== tb/sv/windowed_note_statistics_tb.sv =====
// Testbench for windowed_note_statistics: self-checking, with a scoreboard class and random stalls.
`default_nettype none
module windowed_note_statistics_tb;

  localparam int CLK_PERIOD = 12;

  // One published result as the block reports it
  typedef struct packed {
    logic [wns_pkg::DENSITY_W-1:0] density;
    logic [wns_pkg::AVERAGE_W-1:0] average;
    logic                          kick;
    logic                          closed;
  } published_t;

  // Track the window statistics and hold the results still owed by the block
  class note_window_tracker;
    logic [wns_pkg::WIN_W-1:0]      window_len;
    logic [wns_pkg::NOTE_W-1:0]     pitch_limit;
    logic [wns_pkg::NOTE_W-1:0]     vel_floor;
    logic [wns_pkg::CFG_DATA_W-1:0] kicks_needed;
    logic [wns_pkg::TIME_W-1:0]     window_start;
    logic [wns_pkg::COUNT_BITS-1:0] note_cnt;
    logic [wns_pkg::SUM_W-1:0]      vel_sum;
    logic [wns_pkg::COUNT_BITS-1:0] kick_cnt;
    logic [wns_pkg::DENSITY_W-1:0]  dens;
    logic [wns_pkg::AVERAGE_W-1:0]  avg;
    logic                           kick_flag;
    published_t                     published_q[$];
    int unsigned errors, requests, notes, dropped, closes, writes;

    function new();
      window_len   = wns_pkg::WINDOW_MS_RESET;
      pitch_limit  = wns_pkg::KICK_PITCH_RESET;
      vel_floor    = wns_pkg::KICK_VELOCITY_RESET;
      kicks_needed = wns_pkg::KICK_COUNT_MIN_RESET;
      window_start = '0;
      note_cnt     = '0;
      vel_sum      = '0;
      kick_cnt     = '0;
      dens         = '0;
      avg          = '0;
      kick_flag    = 1'b0;
      errors = 0; requests = 0; notes = 0; dropped = 0; closes = 0; writes = 0;
    endfunction

    function void set_register(wns_pkg::cfg_idx_t idx,
                               logic [wns_pkg::CFG_DATA_W-1:0] data);
      writes++;
      case (idx)
        wns_pkg::CFG_WINDOW_MS:      window_len   = data[wns_pkg::WIN_W-1:0];
        wns_pkg::CFG_KICK_PITCH:     pitch_limit  = data[wns_pkg::NOTE_W-1:0];
        wns_pkg::CFG_KICK_VELOCITY:  vel_floor    = data[wns_pkg::NOTE_W-1:0];
        wns_pkg::CFG_KICK_COUNT_MIN: kicks_needed = data;
        default: ;
      endcase
    endfunction

    // Publish density, average and kick flag, then restart the window
    function void close_window(logic [wns_pkg::TIME_W-1:0] stamp);
      longint unsigned ratio;
      if (window_len == '0) begin
        dens = (note_cnt != '0) ? wns_pkg::DENSITY_MAX : '0;
      end else begin
        ratio = note_cnt;
        ratio = ((ratio * 1000) << wns_pkg::FRAC_BITS) / window_len;
        dens  = (ratio > wns_pkg::DENSITY_MAX) ? wns_pkg::DENSITY_MAX
                                               : wns_pkg::DENSITY_W'(ratio);
      end
      if (note_cnt != '0) begin
        ratio = vel_sum;
        ratio = (ratio << wns_pkg::AVG_FRAC) / note_cnt;
        avg   = (ratio > wns_pkg::AVERAGE_MAX) ? wns_pkg::AVERAGE_MAX
                                               : wns_pkg::AVERAGE_W'(ratio);
      end else begin
        avg = avg >> 1;
      end
      kick_flag    = (kick_cnt >= kicks_needed);
      window_start = stamp;
      note_cnt     = '0;
      vel_sum      = '0;
      kick_cnt     = '0;
    endfunction

    // Apply one accepted request and queue the result it owes
    function void take_request(logic kind, logic [wns_pkg::TIME_W-1:0] stamp,
                               logic [wns_pkg::NOTE_W-1:0] note_pitch,
                               logic [wns_pkg::NOTE_W-1:0] note_vel);
      published_t                 res;
      logic [wns_pkg::TIME_W-1:0] elapsed;
      res.closed = 1'b0;
      requests++;
      if (kind == wns_pkg::OP_NOTE) begin
        notes++;
        if (note_cnt != wns_pkg::COUNT_MAX) begin
          note_cnt++;
          vel_sum += note_vel;
          if (note_pitch < pitch_limit && note_vel > vel_floor) kick_cnt++;
        end else begin
          dropped++;
        end
      end else begin
        elapsed = stamp - window_start;
        if (elapsed >= wns_pkg::TIME_W'(window_len)) begin
          close_window(stamp);
          res.closed = 1'b1;
          closes++;
        end
      end
      res.density = dens;
      res.average = avg;
      res.kick    = kick_flag;
      published_q.push_back(res);
    endfunction

    function int pending();
      return published_q.size();
    endfunction

    // Compare one result with the oldest one owed
    function void match_result(logic [wns_pkg::DENSITY_W-1:0] got_dens,
                               logic [wns_pkg::AVERAGE_W-1:0] got_avg,
                               logic got_kick, logic got_closed);
      published_t want;
      if (published_q.size() == 0) begin
        $error("result with none outstanding: density %0d average %0d kick %0d closed %0d",
               got_dens, got_avg, got_kick, got_closed);
        errors++;
        return;
      end
      want = published_q.pop_front();
      if (got_dens !== want.density) begin
        $error("density: expected %0d, actual %0d", want.density, got_dens);
        errors++;
      end
      if (got_avg !== want.average) begin
        $error("velocity_average: expected %0d, actual %0d", want.average, got_avg);
        errors++;
      end
      if (got_kick !== want.kick) begin
        $error("kick_heavy: expected %0d, actual %0d", want.kick, got_kick);
        errors++;
      end
      if (got_closed !== want.closed) begin
        $error("window_closed: expected %0d, actual %0d", want.closed, got_closed);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            op;
  logic [wns_pkg::TIME_W-1:0]      current_time;
  logic [wns_pkg::NOTE_W-1:0]      pitch;
  logic [wns_pkg::NOTE_W-1:0]      velocity;
  logic                            out_valid;
  logic                            out_stall;
  logic [wns_pkg::DENSITY_W-1:0]   density;
  logic [wns_pkg::AVERAGE_W-1:0]   velocity_average;
  logic                            kick_heavy;
  logic                            window_closed;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wns_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [wns_pkg::CFG_DATA_W-1:0]  cfg_data;

  note_window_tracker         tracker;
  bit                         idle_on = 1'b1;
  logic [wns_pkg::TIME_W-1:0] clock_ms;

  windowed_note_statistics i_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 13);
  end

  // Check every result taken from the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.match_result(density, velocity_average, kick_heavy, window_closed);
    end
  end

  // Present one request, holding it until taken
  task automatic send_request(input logic kind, input logic [wns_pkg::TIME_W-1:0] stamp,
                              input logic [wns_pkg::NOTE_W-1:0] note_pitch,
                              input logic [wns_pkg::NOTE_W-1:0] note_vel);
    if (idle_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    current_time <= stamp;
    pitch        <= note_pitch;
    velocity     <= note_vel;
    do @(posedge clk); while (in_stall);
    tracker.take_request(kind, stamp, note_pitch, note_vel);
  endtask

  // Time items carry random note fields, notes carry a random time
  task automatic send_time(input logic [wns_pkg::TIME_W-1:0] stamp);
    send_request(wns_pkg::OP_TIME, stamp, wns_pkg::NOTE_W'($urandom),
                 wns_pkg::NOTE_W'($urandom));
  endtask

  task automatic send_note(input logic [wns_pkg::NOTE_W-1:0] note_pitch,
                           input logic [wns_pkg::NOTE_W-1:0] note_vel);
    send_request(wns_pkg::OP_NOTE, wns_pkg::TIME_W'($urandom), note_pitch, note_vel);
  endtask

  // Hold off requests until every owed result has come back
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (tracker.pending() != 0 && guard < 20000);
    if (tracker.pending() != 0) begin
      $error("%0d results still outstanding after %0d cycles", tracker.pending(), guard);
      tracker.errors++;
    end
  endtask

  // Write one register, leaving cfg_valid high for the caller to drop
  task automatic put_register(input wns_pkg::cfg_idx_t idx,
                              input logic [wns_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
  endtask

  // Write all four registers while the block is idle
  task automatic configure(input logic [wns_pkg::CFG_DATA_W-1:0] win,
                           input logic [wns_pkg::CFG_DATA_W-1:0] plim,
                           input logic [wns_pkg::CFG_DATA_W-1:0] vmin,
                           input logic [wns_pkg::CFG_DATA_W-1:0] kmin);
    put_register(wns_pkg::CFG_WINDOW_MS, win);
    put_register(wns_pkg::CFG_KICK_PITCH, plim);
    put_register(wns_pkg::CFG_KICK_VELOCITY, vmin);
    put_register(wns_pkg::CFG_KICK_COUNT_MIN, kmin);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int unsigned                pick;
    int unsigned                win;
    logic [wns_pkg::NOTE_W-1:0] plim;
    logic [wns_pkg::NOTE_W-1:0] vmin;
    logic [15:0]                kmin;
    tracker      = new();
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= wns_pkg::OP_TIME;
    current_time <= '0;
    pitch        <= '0;
    velocity     <= '0;
    out_stall    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= wns_pkg::CFG_WINDOW_MS;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: kick boundaries, exact window edge, empty window, wrapping time
    send_time(32'd0);
    send_note(7'd0, 7'd127);
    send_note(7'd127, 7'd0);
    send_note(7'd47, 7'd81);
    send_note(7'd48, 7'd81);
    send_note(7'd47, 7'd80);
    repeat (3) send_note(7'd10, 7'd100);
    send_time(32'd1999);
    send_time(32'd2000);
    send_time(32'd4000);
    send_time(32'd4001);
    send_time(32'hFFFF_FFFF);
    send_note(7'd20, 7'd64);
    send_time(32'h0000_07CE);
    send_time(32'h0000_07CF);
    send_time(32'h0000_0010);

    // Zero window length: every time item closes
    drain_results();
    configure(16'd0, 16'hFF7F, 16'hFF80, 16'd0);
    send_time(32'h0000_0010);
    send_note(7'd126, 7'd1);
    send_note(7'd127, 7'd1);
    send_time(32'h0000_0011);

    // Longest window, no note can be a kick
    drain_results();
    configure(16'hFFFF, 16'hFF80, 16'h007F, 16'hFFFF);
    send_note(7'd0, 7'd127);
    send_note(7'd127, 7'd127);
    send_time(32'h0000_0011 + 32'd65534);
    send_time(32'h0000_0011 + 32'd65535);

    // One millisecond window packed with kicks: density saturates, no idling
    drain_results();
    configure(16'd1, 16'd64, 16'd20, 16'd3);
    idle_on = 1'b0;
    send_time(32'h0002_0000);
    repeat (70) begin
      send_note(wns_pkg::NOTE_W'($urandom_range(0, 63)),
                wns_pkg::NOTE_W'($urandom_range(21, 127)));
    end
    send_time(32'h0002_0001);
    drain_results();
    idle_on = 1'b1;

    // Random windows under several settings
    clock_ms = 32'h0003_0000;
    for (int ph = 0; ph < 5; ph++) begin
      plim = wns_pkg::NOTE_W'($urandom);
      vmin = wns_pkg::NOTE_W'($urandom);
      kmin = 16'($urandom_range(0, 8));
      case (ph)
        0: begin win = 100; plim = 7'd48; vmin = 7'd80; end
        1: win = 60000;
        2: win = $urandom_range(100, 3000);
        3: begin win = $urandom_range(0, 65535); kmin = 16'($urandom); end
        default: begin win = $urandom_range(500, 5000); kmin = 16'd0; end
      endcase
      drain_results();
      configure(16'(win), {9'($urandom), plim}, {9'($urandom), vmin}, kmin);
      for (int k = 0; k < 100; k++) begin
        if (k == 50) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) clock_ms = $urandom;
          else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, win);
          else if (pick < 8) clock_ms = clock_ms - $urandom_range(1, 50);
          else clock_ms = clock_ms + $urandom_range(0, win / 3 + 1);
          send_time(clock_ms);
        end else if ($urandom_range(0, 1) == 0) begin
          send_note(wns_pkg::NOTE_W'($urandom), wns_pkg::NOTE_W'($urandom));
        end else begin
          send_note(wns_pkg::NOTE_W'($urandom_range(0, 50)),
                    wns_pkg::NOTE_W'($urandom_range(60, 127)));
        end
      end
    end

    // Wait out the last results, then allow for a stray one
    drain_results();
    repeat (100) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.errors++;
    end
    $display("Ran %0d requests: %0d notes (%0d dropped at full count), %0d window closes",
             tracker.requests, tracker.notes, tracker.dropped, tracker.closes);
    $display("across %0d register writes, with random idles and output stalls",
             tracker.writes);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(CLK_PERIOD * 1_500_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
